### rtl/wsfd_pkg.sv
`timescale 1ns / 1ps

package wsfd_pkg;

	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] MASK_BIT    = 8'h80;
	localparam logic [7:0] LEN7_MASK   = 8'h7f;
	localparam logic [6:0] LEN7_MAX    = 7'd125;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       frame_end;
		logic       message_end;
	} result_t;

endpackage

### rtl/wsfd_in_reg.sv
`timescale 1ns / 1ps

module wsfd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic load;

	assign load       = advance || !valid_s1;
	assign data_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

### rtl/wsfd_parser.sv
`timescale 1ns / 1ps

module wsfd_parser
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output result_t    result
);

	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic        mask_q, mask_d;
	logic [3:0]  hdr_left_q, hdr_left_d;
	logic [63:0] remaining_q, remaining_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  offset_q, offset_d;
	logic [6:0]  len7;
	logic [3:0]  hdr_left_dec;
	logic [7:0]  key_byte;
	logic        last;
	logic        length_done;
	logic        header_done;
	logic [63:0] length_val;

	assign len7         = byte_s1[6:0] & LEN7_MASK[6:0];
	assign hdr_left_dec = hdr_left_q - 4'd1;
	assign last         = (remaining_q == 64'd1);

	always_comb begin
		case (offset_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		fin_d       = fin_q;
		mask_d      = mask_q;
		hdr_left_d  = hdr_left_q;
		remaining_d = remaining_q;
		key_d       = key_q;
		offset_d    = offset_q;
		length_done = 1'b0;
		header_done = 1'b0;
		length_val  = remaining_q;
		result      = '0;

		case (phase_q)
			PH_HDR1: begin
				mask_d = (byte_s1 & MASK_BIT) != 8'h00;
				if (len7 <= LEN7_MAX) begin
					length_val  = {57'd0, len7};
					remaining_d = length_val;
					length_done = 1'b1;
				end else begin
					remaining_d = '0;
					hdr_left_d  = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d     = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				length_val  = {remaining_q[55:0], byte_s1};
				remaining_d = length_val;
				hdr_left_d  = hdr_left_dec;
				length_done = (hdr_left_dec == 4'd0);
			end
			PH_MASK: begin
				key_d       = {key_q[23:0], byte_s1};
				hdr_left_d  = hdr_left_dec;
				header_done = (hdr_left_dec == 4'd0);
			end
			PH_PAYLOAD: begin
				offset_d             = offset_q + 2'd1;
				remaining_d          = remaining_q - 64'd1;
				result.valid         = 1'b1;
				result.payload_byte  = mask_q ? (byte_s1 ^ key_byte) : byte_s1;
				result.has_byte      = 1'b1;
				result.frame_end     = last;
				result.message_end   = last && fin_q;
				if (last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d   = (byte_s1 & FIN_BIT) != 8'h00;
				phase_d = PH_HDR1;
			end
		endcase

		if (length_done) begin
			if (mask_d) begin
				hdr_left_d = KEY_BYTES;
				key_d      = '0;
				phase_d    = PH_MASK;
			end else begin
				header_done = 1'b1;
			end
		end

		if (header_done) begin
			offset_d = 2'd0;
			if (length_val != 64'd0) begin
				phase_d = PH_PAYLOAD;
			end else begin
				phase_d = PH_HDR0;
				if (fin_q) begin
					result.valid       = 1'b1;
					result.frame_end   = 1'b1;
					result.message_end = 1'b1;
				end
			end
		end

		if (!step) begin
			result.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			fin_q       <= 1'b0;
			mask_q      <= 1'b0;
			hdr_left_q  <= '0;
			remaining_q <= '0;
			key_q       <= '0;
			offset_q    <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			fin_q       <= fin_d;
			mask_q      <= mask_d;
			hdr_left_q  <= hdr_left_d;
			remaining_q <= remaining_d;
			key_q       <= key_d;
			offset_q    <= offset_d;
		end
	end

endmodule

### rtl/wsfd_out_reg.sv
`timescale 1ns / 1ps

module wsfd_out_reg
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  result_t    result,
	output logic       advance,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       frame_end,
	output logic       message_end
);

	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			payload_byte <= result.payload_byte;
			has_byte     <= result.has_byte;
			frame_end    <= result.frame_end;
			message_end  <= result.message_end;
		end
	end

endmodule

### rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// WebSocket frame deframer. The input channel carries one stream byte per
// transaction on data_byte, header and payload bytes alike. The output
// channel carries one transaction per payload byte, unmasked with the frame's
// key if masked; a final frame of zero length gives one with has_byte low.
// frame_end marks the last transaction of a frame and message_end the last
// transaction of a frame whose FIN bit was set. Header bytes give no output.
// A byte is registered on acceptance, parsed once the output register can
// advance and its result registered, so a result is offered in the cycle
// after the byte is parsed. One byte is taken every cycle when not stalled.
// The rate is set by the single parse stage, where each byte needs only a
// header state update or an XOR and a 64-bit length decrement.
// Reset clears both stage valid flags; the parser returns to the first header
// byte. When the receiver stalls, the output register holds its result, the
// input register fills and then data_stall is raised until the output drains.

module websocket_frame_deframer
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       frame_end,
	output logic       message_end
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	result_t    result;

	wsfd_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	wsfd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.result       (result),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.frame_end    (frame_end),
		.message_end  (message_end)
	);

endmodule

### rtl/wsfd_checker.sv
`timescale 1ns / 1ps

module wsfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] payload_byte,
	input logic       has_byte,
	input logic       frame_end,
	input logic       message_end
);

	a_msg_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && message_end |-> frame_end)
		else $error("message end outside a frame end");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |-> frame_end && message_end)
		else $error("empty result that does not close a message");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(data_valid && !data_stall, 2))
		else $error("result without an accepted byte two cycles earlier");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(payload_byte)
			&& $stable(has_byte) && $stable(frame_end) && $stable(message_end))
		else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.data_valid   (data_valid),
	.data_stall   (data_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.payload_byte (payload_byte),
	.has_byte     (has_byte),
	.frame_end    (frame_end),
	.message_end  (message_end)
);
